// ===== rtl/pfblit_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel blit package
// Shared constants, register indexes, format codes and record types.
// ----------------------------------------------------------------------------
package pfblit_pkg;

   localparam int MAX_SCREEN_WIDTH  = 1024;
   localparam int MAX_SCREEN_HEIGHT = 1024;

   localparam int XW          = $clog2(MAX_SCREEN_WIDTH);
   localparam int YW          = $clog2(MAX_SCREEN_HEIGHT);
   localparam int INDEX_W     = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_LEFT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_TOP       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_COLUMNS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_COLUMNS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_ROWS    = 3'd5;

   localparam logic [2:0] FMT_RGB565   = 3'd0;
   localparam logic [2:0] FMT_RGB888   = 3'd1;
   localparam logic [2:0] FMT_XRGB8888 = 3'd2;
   localparam logic [2:0] FMT_ARGB8888 = 3'd3;

   localparam logic [7:0]  GREY_LEVEL        = 8'd128;
   localparam logic [11:0] AREA_COLUMNS_MAX  = 12'd2048;

   typedef struct packed {
      logic signed [11:0] area_left;
      logic signed [11:0] area_top;
      logic [11:0]        area_columns;
      logic [2:0]         pixel_format;
      logic [10:0]        screen_columns;
      logic [10:0]        screen_rows;
   } pfblit_cfg_type;

   typedef struct packed {
      logic          enable;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
   } pfblit_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pfblit_q_stat_type;

endpackage

// ===== rtl/pfblit_if.sv =====
// ----------------------------------------------------------------------------
// Pixel blit channel interfaces
// Valid/ready channels for pixel requests, results and register writes.
// ----------------------------------------------------------------------------
interface pfblit_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_word;
   logic        start_of_area;

   modport source (output valid, output pixel_word, output start_of_area, input ready);
   modport sink (input valid, input pixel_word, input start_of_area, output ready);
endinterface

interface pfblit_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [19:0] pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source (output valid, output write_enable, output pixel_index,
                   output red, output green, output blue, input ready);
   modport sink (input valid, input write_enable, input pixel_index,
                 input red, input green, input blue, output ready);
endinterface

interface pfblit_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pfblit_front.sv =====
// ----------------------------------------------------------------------------
// Pixel blit front end
// Accepts pixels, tracks the area position, clips and converts the color.
// ----------------------------------------------------------------------------
module pfblit_front
   import pfblit_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   pfblit_req_if.sink        req_chan,
   input  pfblit_cfg_type    cfg,
   input  logic [10:0]       width,
   input  logic [10:0]       height,
   input  pfblit_q_stat_type q_stat,
   output logic              push,
   output pfblit_item_type   push_item
);

   logic [10:0] column_ff, column_in;
   logic [10:0] row_ff, row_in;
   logic [10:0] column_cur, row_cur;
   logic [11:0] cols_eff;
   logic [11:0] column_next;
   logic [12:0] x, y;
   logic        on_screen;
   logic [31:0] w;

   assign req_chan.ready = !q_stat.full;
   assign push = req_chan.valid && !q_stat.full;
   assign w = req_chan.pixel_word;

   always_comb begin
      column_cur = req_chan.start_of_area ? '0 : column_ff;
      row_cur    = req_chan.start_of_area ? '0 : row_ff;

      if (cfg.area_columns == '0) begin
         cols_eff = 12'd1;
      end else if (cfg.area_columns > AREA_COLUMNS_MAX) begin
         cols_eff = AREA_COLUMNS_MAX;
      end else begin
         cols_eff = cfg.area_columns;
      end

      column_next = {1'b0, column_cur} + 12'd1;
      if (column_next >= cols_eff) begin
         column_in = '0;
         row_in    = row_cur + 11'd1;
      end else begin
         column_in = column_next[10:0];
         row_in    = row_cur;
      end

      x = {cfg.area_left[11], cfg.area_left} + {2'b00, column_cur};
      y = {cfg.area_top[11], cfg.area_top} + {2'b00, row_cur};
      on_screen = !x[12] && !y[12] && (x[11:0] < {1'b0, width})
                  && (y[11:0] < {1'b0, height});

      push_item.enable = on_screen;
      push_item.x      = x[XW-1:0];
      push_item.y      = y[YW-1:0];

      if (cfg.pixel_format == FMT_RGB565) begin
         push_item.red   = {w[15:11], w[15:13]};
         push_item.green = {w[10:5], w[10:9]};
         push_item.blue  = {w[4:0], w[4:2]};
      end else if (cfg.pixel_format inside {FMT_RGB888, FMT_XRGB8888, FMT_ARGB8888}) begin
         push_item.red   = w[23:16];
         push_item.green = w[15:8];
         push_item.blue  = w[7:0];
      end else begin
         push_item.red   = GREY_LEVEL;
         push_item.green = GREY_LEVEL;
         push_item.blue  = GREY_LEVEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (push) begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== rtl/pfblit_queue.sv =====
// ----------------------------------------------------------------------------
// Pixel blit queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pfblit_queue
   import pfblit_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfblit_item_type   push_item,
   input  logic              pop,
   output pfblit_item_type   pop_item,
   output pfblit_q_stat_type q_stat
);

   pfblit_item_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/pfblit_back.sv =====
// ----------------------------------------------------------------------------
// Pixel blit back end
// Computes the destination index and holds the result in an output register.
// ----------------------------------------------------------------------------
module pfblit_back
   import pfblit_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [10:0]       width,
   input  pfblit_q_stat_type q_stat,
   input  pfblit_item_type   pop_item,
   output logic              pop,
   pfblit_rsp_if.source      rsp_chan
);

   logic               valid_ff, valid_in;
   logic               enable_ff;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [7:0]         red_ff, green_ff, blue_ff;
   logic [31:0]        product;

   assign pop = !q_stat.empty && (!valid_ff || rsp_chan.ready);

   always_comb begin
      product  = 32'(pop_item.y) * 32'(width) + 32'(pop_item.x);
      index_in = pop_item.enable ? product[INDEX_W-1:0] : '0;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         enable_ff <= pop_item.enable;
         index_ff  <= index_in;
         red_ff    <= pop_item.red;
         green_ff  <= pop_item.green;
         blue_ff   <= pop_item.blue;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.write_enable = enable_ff;
   assign rsp_chan.pixel_index  = index_ff;
   assign rsp_chan.red          = red_ff;
   assign rsp_chan.green        = green_ff;
   assign rsp_chan.blue         = blue_ff;

endmodule

// ===== rtl/pixel_format_to_rgb888_blit_core.sv =====
// ----------------------------------------------------------------------------
// Pixel format to RGB888 blit core
// Converts the pixels of one screen area to RGB888 with screen clipping.
//
// Source pixels of a rectangular area arrive in raster order on the req
// channel, one 32-bit word per transfer; start_of_area returns the position
// to the area origin. Each pixel gives one rsp transfer with the destination
// index, the RGB888 color and a write enable that is low off screen.
// The user must write registers on the csr channel only while no pixel is
// in flight; the block itself does not enforce this. An accepted pixel is
// written to the queue, then to the output register that drives the rsp channel.
// Without a receiver stall one pixel is accepted per cycle, and the front end,
// two-entry queue and output register let a transfer follow another every cycle.
// When the receiver stalls, the output register holds its result and the
// queue fills; req ready drops once both queue entries are taken.
// Synchronous reset empties the queue and output register, returns the
// area position to the origin and the registers to their reset values.
// ----------------------------------------------------------------------------
module pixel_format_to_rgb888_blit_core
   import pfblit_pkg::*;
(
   input logic          clock,
   input logic          reset,
   pfblit_req_if.sink   req_chan,
   pfblit_rsp_if.source rsp_chan,
   pfblit_csr_if.sink   csr_chan
);

   pfblit_cfg_type    cfg_ff;
   logic [10:0]       width, height;
   pfblit_q_stat_type q_stat;
   logic              push, pop;
   pfblit_item_type   push_item, pop_item;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_left      <= '0;
         cfg_ff.area_top       <= '0;
         cfg_ff.area_columns   <= 12'd1;
         cfg_ff.pixel_format   <= FMT_RGB565;
         cfg_ff.screen_columns <= 11'd1024;
         cfg_ff.screen_rows    <= 11'd1024;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_AREA_LEFT:      cfg_ff.area_left      <= csr_chan.data;
            CSR_AREA_TOP:       cfg_ff.area_top       <= csr_chan.data;
            CSR_AREA_COLUMNS:   cfg_ff.area_columns   <= csr_chan.data;
            CSR_PIXEL_FORMAT:   cfg_ff.pixel_format   <= csr_chan.data[2:0];
            CSR_SCREEN_COLUMNS: cfg_ff.screen_columns <= csr_chan.data[10:0];
            CSR_SCREEN_ROWS:    cfg_ff.screen_rows    <= csr_chan.data[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (32'(cfg_ff.screen_columns) > MAX_SCREEN_WIDTH) begin
         width = 11'(MAX_SCREEN_WIDTH);
      end else begin
         width = cfg_ff.screen_columns;
      end
      if (32'(cfg_ff.screen_rows) > MAX_SCREEN_HEIGHT) begin
         height = 11'(MAX_SCREEN_HEIGHT);
      end else begin
         height = cfg_ff.screen_rows;
      end
   end

   pfblit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .width     (width),
      .height    (height),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   pfblit_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   pfblit_back u_back (
      .clock    (clock),
      .reset    (reset),
      .width    (width),
      .q_stat   (q_stat),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_off_screen_index_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.write_enable |-> rsp_chan.pixel_index == '0)
      else $error("Disabled pixel carries a nonzero index.");

   a_index_on_screen : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.write_enable
      |-> 32'(rsp_chan.pixel_index) < 32'(width) * 32'(height))
      else $error("Enabled pixel index lies beyond the screen.");

   a_reset_clears_output : assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("Result valid directly after reset.");

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_chan.ready && rsp_chan.valid)
      else $error("Queue full while the output register is empty.");

endmodule
